// ===== rtl/gmr_pkg.sv =====
package gmr_pkg;

  // grid dimensions, fixed by the port widths
  localparam int MaxLevels = 8;
  localparam int MaxSide   = 32;

  // commands
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // cell kinds
  typedef enum logic [2:0] {
    KIND_OPEN   = 3'd0,
    KIND_WALL   = 3'd1,
    KIND_START  = 3'd2,
    KIND_HANGAR = 3'd3,
    KIND_ELEV   = 3'd4
  } kind_e;

  // moves, used for arrival moves and path marks
  typedef enum logic [2:0] {
    MOVE_NONE = 3'd0,
    MOVE_N    = 3'd1,
    MOVE_E    = 3'd2,
    MOVE_S    = 3'd3,
    MOVE_W    = 3'd4,
    MOVE_ELEV = 3'd5
  } move_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LEVEL_COUNT = 2'd0,
    REG_GRID_SIZE   = 2'd1,
    REG_ORDER_MODE  = 2'd2
  } reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_POP,
    ST_POP_WAIT,
    ST_CUR,
    ST_NB,
    ST_NB_CHK,
    ST_EL,
    ST_EL_CHK,
    ST_FIN,
    ST_FIN_CHK,
    ST_TR_RD,
    ST_TR_CHK
  } state_e;

  // work list control
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic front;
  } wl_ctrl_t;

  localparam int KindW = 3;
  localparam int MoveW = 3;
  localparam int PathW = 6;

  // move that leads back to the cell a step came from
  function automatic move_e opposite(input move_e m);
    move_e r;
    case (m)
      MOVE_N:  r = MOVE_S;
      MOVE_S:  r = MOVE_N;
      MOVE_E:  r = MOVE_W;
      MOVE_W:  r = MOVE_E;
      default: r = MOVE_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gmr_ram.sv =====
module gmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gmr_step.sv =====
module gmr_step
  import gmr_pkg::*;
#(
  parameter int SW  = 5,
  parameter int SDW = 6
) (
  input  logic [SW-1:0]  row_i,
  input  logic [SW-1:0]  col_i,
  input  move_e          dir_i,
  input  logic [SDW-1:0] side_i,
  output logic           valid_o,
  output logic [SW-1:0]  row_o,
  output logic [SW-1:0]  col_o
);

  // neighbor coordinate and bounds check for one move
  always_comb begin
    valid_o = 1'b0;
    row_o   = row_i;
    col_o   = col_i;
    case (dir_i)
      MOVE_N: begin
        valid_o = (row_i != '0);
        row_o   = row_i - SW'(1);
      end
      MOVE_E: begin
        valid_o = (32'(col_i) + 32'd1) < 32'(side_i);
        col_o   = col_i + SW'(1);
      end
      MOVE_S: begin
        valid_o = (32'(row_i) + 32'd1) < 32'(side_i);
        row_o   = row_i + SW'(1);
      end
      MOVE_W: begin
        valid_o = (col_i != '0);
        col_o   = col_i - SW'(1);
      end
      default: valid_o = 1'b0;
    endcase
  end

endmodule

// ===== rtl/gmr_wlist.sv =====
module gmr_wlist
  import gmr_pkg::*;
#(
  parameter int AW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wl_ctrl_t      ctrl_i,
  input  logic [AW-1:0] push_addr_i,
  output logic [AW-1:0] pop_addr_o,
  output logic          empty_o
);

  localparam int Depth = 1 << AW;

  logic [AW-1:0] head_q, head_d;
  logic [AW:0]   count_q, count_d;
  logic [AW-1:0] waddr;

  // head and fill count of the ring
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    waddr   = head_q + count_q[AW-1:0];
    if (ctrl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctrl_i.push) begin
      count_d = count_q + (AW+1)'(1);
      if (ctrl_i.front) begin
        waddr  = head_q - AW'(1);
        head_d = head_q - AW'(1);
      end
    end else if (ctrl_i.pop) begin
      head_d  = head_q + AW'(1);
      count_d = count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // entry storage
  gmr_ram #(.WIDTH(AW), .DEPTH(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push && !ctrl_i.clear),
    .waddr_i (waddr),
    .wdata_i (push_addr_i),
    .raddr_i (head_q),
    .rdata_o (pop_addr_o)
  );

  assign empty_o = (count_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (32'(count_q) < Depth)) else $error("work list overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !empty_o) else $error("work list underflow");
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop)) else $error("push and pop together");

endmodule

// ===== rtl/grid_maze_route_search.sv =====
// Grid maze route search. One request is taken when start_i is high and busy_o is
// low; its single result appears on the result ports for one cycle with done_o, and
// the receiver must take it then. A cell write is done in the idle state and a cell
// read through the read state, both through one port of the cell memories. After
// reset, on a clear request and at the start of each search, a clearing pass walks
// every memory word, one a cycle, 2**(LW+2*SW) words, 8192 for eight levels of 32
// by 32, busy all the while; a search pass keeps the cell kinds. A search then runs
// on one memory port under a small sequencer that takes cells from the work list,
// checks their neighbors and, for elevator cells, each level, and traces the route.
// The user must write configuration only while idle; the block does not enforce it.
module grid_maze_route_search
  import gmr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] command_i,
  input  logic [2:0] level_i,
  input  logic [4:0] row_i,
  input  logic [4:0] column_i,
  input  logic [2:0] cell_kind_i,
  output logic       done_o,
  output logic [2:0] kind_read_o,
  output logic [2:0] path_mark_o,
  output logic [2:0] path_level_o,
  output logic       found_o,
  output logic       error_o
);

  localparam int LW    = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int SW    = $clog2(MaxSide);
  localparam int AW    = LW + 2 * SW;
  localparam int Depth = 1 << AW;
  localparam int ULW   = $clog2(MaxLevels + 1);
  localparam int USW   = $clog2(MaxSide + 1);
  localparam int WalkW = 1 + MoveW + LW;

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] lv, input logic [7:0] r,
                                              input logic [7:0] c);
    return {lv[LW-1:0], r[SW-1:0], c[SW-1:0]};
  endfunction

  function automatic logic in_grid(input logic [7:0] lv, input logic [7:0] r,
                                   input logic [7:0] c, input logic [ULW-1:0] nl,
                                   input logic [USW-1:0] ns);
    return (32'(lv) < 32'(nl)) && (32'(r) < 32'(ns)) && (32'(c) < 32'(ns));
  endfunction

  state_e          state_q, state_d;
  cmd_e            op_q, op_d;
  logic            sweep_kind_q, sweep_kind_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [12:0]     start_q, start_d, hangar_q, hangar_d;
  logic [AW-1:0]   cur_q, cur_d, nb_q, nb_d, pos_q, pos_d;
  logic [2:0]      cur_kind_q, cur_kind_d;
  move_e           dir_q, dir_d;
  logic [ULW-1:0]  lvi_q, lvi_d;
  logic [3:0]      lvl_q;
  logic [5:0]      grid_q;
  logic            order_q;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_kind_q, out_kind_d, out_mark_q, out_mark_d, out_plv_q, out_plv_d;
  logic            out_found_q, out_found_d, out_err_q, out_err_d;

  logic [ULW-1:0]  used_lv;
  logic [USW-1:0]  used_side;

  // memory ports
  logic [AW-1:0]   rd_addr;
  logic            kind_we, walk_we, path_we;
  logic [AW-1:0]   kind_waddr, walk_waddr, path_waddr;
  logic [KindW-1:0] kind_wdata, kind_rdata;
  logic [WalkW-1:0] walk_wdata, walk_rdata;
  logic [PathW-1:0] path_wdata, path_rdata;

  wl_ctrl_t        wl_ctrl;
  logic [AW-1:0]   wl_push, wl_pop;
  logic            wl_empty;

  // step unit
  logic [SW-1:0]   st_row, st_col, st_nrow, st_ncol;
  move_e           st_dir;
  logic            st_valid;

  // field views
  logic [LW-1:0]   cur_lv, pos_lv, came_lv;
  logic [SW-1:0]   cur_r, cur_c, pos_r, pos_c;
  logic            seen_rd;
  move_e           came_rd;
  logic            in_ok, start_ok, hangar_ok, last_dir, nb_take;
  logic [AW-1:0]   start_addr, hangar_addr, in_addr, pred_addr;

  // saturated level count and side
  always_comb begin
    if (lvl_q == '0) used_lv = ULW'(1);
    else if (32'(lvl_q) > MaxLevels) used_lv = ULW'(MaxLevels);
    else used_lv = ULW'(lvl_q);
    if (grid_q == '0) used_side = USW'(1);
    else if (32'(grid_q) > MaxSide) used_side = USW'(MaxSide);
    else used_side = USW'(grid_q);
  end

  assign cur_c   = cur_q[SW-1:0];
  assign cur_r   = cur_q[2*SW-1:SW];
  assign cur_lv  = cur_q[AW-1:2*SW];
  assign pos_c   = pos_q[SW-1:0];
  assign pos_r   = pos_q[2*SW-1:SW];
  assign pos_lv  = pos_q[AW-1:2*SW];
  assign seen_rd = walk_rdata[WalkW-1];
  assign came_rd = move_e'(walk_rdata[WalkW-2:LW]);
  assign came_lv = walk_rdata[LW-1:0];

  assign in_ok = in_grid(8'(level_i), 8'(row_i), 8'(column_i), used_lv, used_side);
  assign start_ok = in_grid(8'(start_q[12:10]), 8'(start_q[9:5]), 8'(start_q[4:0]),
                            used_lv, used_side);
  assign hangar_ok = in_grid(8'(hangar_q[12:10]), 8'(hangar_q[9:5]), 8'(hangar_q[4:0]),
                             used_lv, used_side);
  assign in_addr     = cell_addr(8'(level_i), 8'(row_i), 8'(column_i));
  assign start_addr  = cell_addr(8'(start_q[12:10]), 8'(start_q[9:5]), 8'(start_q[4:0]));
  assign hangar_addr = cell_addr(8'(hangar_q[12:10]), 8'(hangar_q[9:5]),
                                 8'(hangar_q[4:0]));
  assign last_dir = (dir_q == MOVE_W);
  assign nb_take  = (kind_rdata != KIND_WALL) && !seen_rd;

  // step unit serves both the walk and the trace back
  always_comb begin
    if (state_q == ST_TR_CHK) begin
      st_row = pos_r;
      st_col = pos_c;
      st_dir = opposite(came_rd);
    end else begin
      st_row = cur_r;
      st_col = cur_c;
      st_dir = dir_q;
    end
  end

  gmr_step #(.SW(SW), .SDW(USW)) u_step (
    .row_i   (st_row),
    .col_i   (st_col),
    .dir_i   (st_dir),
    .side_i  (used_side),
    .valid_o (st_valid),
    .row_o   (st_nrow),
    .col_o   (st_ncol)
  );

  assign pred_addr = (came_rd == MOVE_ELEV) ? {came_lv, pos_r, pos_c}
                                            : {pos_lv, st_nrow, st_ncol};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (cnt_q == '1) state_d = (op_q == CMD_SEARCH) ? ST_START : ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (cmd_e'(command_i)) inside
            CMD_WRITE:  state_d = ST_IDLE;
            CMD_READ:   state_d = in_ok ? ST_READ : ST_IDLE;
            CMD_SEARCH, CMD_CLEAR: state_d = ST_SWEEP;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:     state_d = ST_IDLE;
      ST_START:    state_d = start_ok ? ST_POP : ST_IDLE;
      ST_POP:      state_d = wl_empty ? ST_FIN : ST_POP_WAIT;
      ST_POP_WAIT: state_d = ST_CUR;
      ST_CUR:      state_d = (kind_rdata == KIND_HANGAR) ? ST_FIN : ST_NB;
      ST_NB: begin
        if (st_valid) state_d = ST_NB_CHK;
        else if (last_dir) state_d = (cur_kind_q == KIND_ELEV) ? ST_EL : ST_POP;
      end
      ST_NB_CHK: begin
        if (nb_take && kind_rdata == KIND_HANGAR) state_d = ST_FIN;
        else if (last_dir) state_d = (cur_kind_q == KIND_ELEV) ? ST_EL : ST_POP;
        else state_d = ST_NB;
      end
      ST_EL:       state_d = (lvi_q < used_lv) ? ST_EL_CHK : ST_POP;
      ST_EL_CHK:   state_d = ST_EL;
      ST_FIN:      state_d = hangar_ok ? ST_FIN_CHK : ST_IDLE;
      ST_FIN_CHK:  state_d = (kind_rdata == KIND_HANGAR && seen_rd) ? ST_TR_RD : ST_IDLE;
      ST_TR_RD:    state_d = ST_TR_CHK;
      ST_TR_CHK:   state_d = (came_rd == MOVE_NONE) ? ST_IDLE : ST_TR_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    op_d         = op_q;
    sweep_kind_d = sweep_kind_q;
    cnt_d        = cnt_q;
    start_d      = start_q;
    hangar_d     = hangar_q;
    cur_d        = cur_q;
    nb_d         = nb_q;
    pos_d        = pos_q;
    cur_kind_d   = cur_kind_q;
    dir_d        = dir_q;
    lvi_d        = lvi_q;
    out_valid_d  = 1'b0;
    out_kind_d   = out_kind_q;
    out_mark_d   = out_mark_q;
    out_plv_d    = out_plv_q;
    out_found_d  = out_found_q;
    out_err_d    = out_err_q;
    rd_addr      = cur_q;
    kind_we      = 1'b0;
    kind_waddr   = cnt_q;
    kind_wdata   = '0;
    walk_we      = 1'b0;
    walk_waddr   = cnt_q;
    walk_wdata   = '0;
    path_we      = 1'b0;
    path_waddr   = cnt_q;
    path_wdata   = '0;
    wl_ctrl      = '0;
    wl_ctrl.front = order_q;
    wl_push      = nb_q;

    unique case (state_q)
      ST_SWEEP: begin
        kind_we = sweep_kind_q;
        walk_we = 1'b1;
        path_we = 1'b1;
        cnt_d   = cnt_q + AW'(1);
        if (cnt_q == '1 && op_q == CMD_CLEAR) begin
          out_valid_d = 1'b1;
          out_kind_d  = '0;
          out_mark_d  = '0;
          out_plv_d   = '0;
          out_found_d = 1'b0;
          out_err_d   = 1'b0;
        end
      end
      ST_IDLE: begin
        rd_addr = in_addr;
        if (start_i) begin
          op_d        = cmd_e'(command_i);
          out_kind_d  = '0;
          out_mark_d  = '0;
          out_plv_d   = '0;
          out_found_d = 1'b0;
          out_err_d   = 1'b0;
          cnt_d       = '0;
          unique case (cmd_e'(command_i))
            CMD_WRITE: begin
              out_valid_d = 1'b1;
              if (!in_ok || cell_kind_i > KIND_ELEV) begin
                out_err_d = 1'b1;
              end else begin
                kind_we    = 1'b1;
                kind_waddr = in_addr;
                kind_wdata = cell_kind_i;
                if (cell_kind_i == KIND_START) start_d = {level_i, row_i, column_i};
                if (cell_kind_i == KIND_HANGAR) hangar_d = {level_i, row_i, column_i};
              end
            end
            CMD_READ: begin
              if (!in_ok) begin
                out_valid_d = 1'b1;
                out_err_d   = 1'b1;
              end
            end
            CMD_SEARCH: begin
              sweep_kind_d  = 1'b0;
              wl_ctrl.clear = 1'b1;
            end
            CMD_CLEAR: begin
              sweep_kind_d  = 1'b1;
              wl_ctrl.clear = 1'b1;
              start_d       = '0;
              hangar_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_d = 1'b1;
        out_kind_d  = kind_rdata;
        out_mark_d  = path_rdata[5:3];
        out_plv_d   = path_rdata[2:0];
      end
      ST_START: begin
        if (!start_ok) begin
          out_valid_d = 1'b1;
          out_err_d   = 1'b1;
        end else begin
          walk_we      = 1'b1;
          walk_waddr   = start_addr;
          walk_wdata   = {1'b1, MOVE_NONE, LW'(0)};
          wl_ctrl.push = 1'b1;
          wl_push      = start_addr;
        end
      end
      ST_POP: begin
        wl_ctrl.pop = !wl_empty;
      end
      ST_POP_WAIT: begin
        rd_addr = wl_pop;
        cur_d   = wl_pop;
      end
      ST_CUR: begin
        cur_kind_d = kind_rdata;
        dir_d      = MOVE_N;
      end
      ST_NB: begin
        nb_d    = {cur_lv, st_nrow, st_ncol};
        rd_addr = {cur_lv, st_nrow, st_ncol};
        if (!st_valid) begin
          dir_d = move_e'(3'(dir_q) + 3'd1);
          lvi_d = '0;
        end
      end
      ST_NB_CHK: begin
        dir_d = move_e'(3'(dir_q) + 3'd1);
        lvi_d = '0;
        if (nb_take) begin
          walk_we      = 1'b1;
          walk_waddr   = nb_q;
          walk_wdata   = {1'b1, dir_q, LW'(0)};
          wl_ctrl.push = 1'b1;
        end
      end
      ST_EL: begin
        nb_d    = {lvi_q[LW-1:0], cur_r, cur_c};
        rd_addr = {lvi_q[LW-1:0], cur_r, cur_c};
      end
      ST_EL_CHK: begin
        lvi_d = lvi_q + ULW'(1);
        if (!seen_rd && kind_rdata == KIND_ELEV) begin
          walk_we      = 1'b1;
          walk_waddr   = nb_q;
          walk_wdata   = {1'b1, MOVE_ELEV, cur_lv};
          wl_ctrl.push = 1'b1;
        end
      end
      ST_FIN: begin
        rd_addr = hangar_addr;
        if (!hangar_ok) out_valid_d = 1'b1;
      end
      ST_FIN_CHK: begin
        pos_d = hangar_addr;
        if (!(kind_rdata == KIND_HANGAR && seen_rd)) out_valid_d = 1'b1;
      end
      ST_TR_RD: begin
        rd_addr = pos_q;
      end
      ST_TR_CHK: begin
        if (came_rd == MOVE_NONE) begin
          out_valid_d = 1'b1;
          out_found_d = 1'b1;
        end else begin
          path_we    = 1'b1;
          path_waddr = pred_addr;
          path_wdata = {came_rd, (came_rd == MOVE_ELEV) ? 3'(pos_lv) : 3'd0};
          pos_d      = pred_addr;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      op_q         <= CMD_WRITE;
      sweep_kind_q <= 1'b1;
      cnt_q        <= '0;
      start_q      <= '0;
      hangar_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      sweep_kind_q <= sweep_kind_d;
      cnt_q        <= cnt_d;
      start_q      <= start_d;
      hangar_q     <= hangar_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // walk registers and result fields
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    nb_q        <= nb_d;
    pos_q       <= pos_d;
    cur_kind_q  <= cur_kind_d;
    dir_q       <= dir_d;
    lvi_q       <= lvi_d;
    out_kind_q  <= out_kind_d;
    out_mark_q  <= out_mark_d;
    out_plv_q   <= out_plv_d;
    out_found_q <= out_found_d;
    out_err_q   <= out_err_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q   <= 4'd1;
      grid_q  <= 6'd1;
      order_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_LEVEL_COUNT: lvl_q   <= cfg_wdata_i[3:0];
        REG_GRID_SIZE:   grid_q  <= cfg_wdata_i;
        REG_ORDER_MODE:  order_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // cell store: kind, walk state and path mark
  gmr_ram #(.WIDTH(KindW), .DEPTH(Depth)) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (kind_we),
    .waddr_i (kind_waddr),
    .wdata_i (kind_wdata),
    .raddr_i (rd_addr),
    .rdata_o (kind_rdata)
  );

  gmr_ram #(.WIDTH(WalkW), .DEPTH(Depth)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (walk_we),
    .waddr_i (walk_waddr),
    .wdata_i (walk_wdata),
    .raddr_i (rd_addr),
    .rdata_o (walk_rdata)
  );

  gmr_ram #(.WIDTH(PathW), .DEPTH(Depth)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .raddr_i (rd_addr),
    .rdata_o (path_rdata)
  );

  gmr_wlist #(.AW(AW)) u_wlist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (wl_ctrl),
    .push_addr_i (wl_push),
    .pop_addr_o  (wl_pop),
    .empty_o     (wl_empty)
  );

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = out_valid_q;
  assign kind_read_o  = out_kind_q;
  assign path_mark_o  = out_mark_q;
  assign path_level_o = out_plv_q;
  assign found_o      = out_found_q;
  assign error_o      = out_err_q;

  a_found_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> !error_o) else $error("found with error");
  a_trace_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TR_CHK) |-> seen_rd) else $error("trace left discovered cells");
  a_nb_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NB_CHK && walk_we) |-> (nb_q != cur_q))
    else $error("neighbor equals current cell");

endmodule
